// File: hdl/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  // Payload bytes carried between header and checksum (range 1 to 16)
  localparam int PAYLOAD_BYTES = 4;
  localparam int OutPayload    = 4;
  localparam int CntW          = $clog2(PAYLOAD_BYTES + 2);
  localparam int SlotW         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  localparam logic [7:0] HeaderReset  = 8'hA5;
  localparam logic [7:0] TrailerReset = 8'hFB;

  typedef enum logic {
    RegHeader  = 1'b0,
    RegTrailer = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CmdByte = 1'b0,
    CmdTake = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    EvStored     = 4'd0,
    EvBadHeader  = 4'd1,
    EvSumOk      = 4'd2,
    EvSumBad     = 4'd3,
    EvFrameDone  = 4'd4,
    EvBadTrailer = 4'd5,
    EvIgnored    = 4'd6,
    EvTaken      = 4'd7,
    EvNone       = 4'd8
  } ev_e;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic       frame_ready;
    logic [7:0] payload_byte1;
    logic [7:0] payload_byte2;
    logic [7:0] payload_byte3;
    logic [7:0] payload_byte4;
  } out_item_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] trailer_byte;
  } cfg_t;

endpackage

`default_nettype wire

// File: hdl/sfr_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_core import sfr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      accept_i,
  input  wire in_item_t  item_i,
  output out_item_t      res_o
);

  logic [CntW-1:0]  byte_count_q, byte_count_d;
  logic             sum_matched_q, sum_matched_d;
  logic             frame_held_q, frame_held_d;
  logic [7:0]       running_sum_q, running_sum_d;
  logic [7:0]       store_q [PAYLOAD_BYTES];
  logic             store_we;
  logic [SlotW-1:0] store_slot;
  logic [CntW-1:0]  slot_wide;
  ev_e              ev;
  logic             show;
  logic [7:0]       shown [OutPayload];

  assign slot_wide  = byte_count_q - CntW'(1);
  assign store_slot = slot_wide[SlotW-1:0];

  always_comb begin
    byte_count_d  = byte_count_q;
    sum_matched_d = sum_matched_q;
    frame_held_d  = frame_held_q;
    running_sum_d = running_sum_q;
    store_we      = 1'b0;
    ev            = EvNone;
    if (item_i.command == CmdTake) begin
      if (frame_held_q) begin
        ev            = EvTaken;
        frame_held_d  = 1'b0;
        byte_count_d  = '0;
        sum_matched_d = 1'b0;
        running_sum_d = '0;
      end
    end else if (frame_held_q) begin
      ev = EvIgnored;
    end else if (sum_matched_q) begin
      if (item_i.rx_byte == cfg_i.trailer_byte) begin
        frame_held_d = 1'b1;
        ev           = EvFrameDone;
      end else begin
        byte_count_d  = '0;
        sum_matched_d = 1'b0;
        running_sum_d = '0;
        ev            = EvBadTrailer;
      end
    end else if (byte_count_q >= CntW'(PAYLOAD_BYTES + 1)) begin
      if (item_i.rx_byte == running_sum_q) begin
        sum_matched_d = 1'b1;
        ev            = EvSumOk;
      end else begin
        byte_count_d  = '0;
        running_sum_d = '0;
        ev            = EvSumBad;
      end
    end else if (byte_count_q == '0) begin
      if (item_i.rx_byte == cfg_i.header_byte) begin
        running_sum_d = item_i.rx_byte;
        byte_count_d  = CntW'(1);
        ev            = EvStored;
      end else begin
        ev = EvBadHeader;
      end
    end else begin
      store_we      = 1'b1;
      running_sum_d = running_sum_q + item_i.rx_byte;
      byte_count_d  = byte_count_q + CntW'(1);
      ev            = EvStored;
    end
  end

  // A take shows the frame it releases; a byte shows the frame held after it
  assign show = (item_i.command == CmdTake) ? frame_held_q : frame_held_d;

  always_comb begin
    for (int j = 0; j < OutPayload; j++) begin
      shown[j] = 8'h00;
      if (show && (j < PAYLOAD_BYTES)) begin
        shown[j] = store_q[(j < PAYLOAD_BYTES) ? j : 0];
      end
    end
  end

  always_comb begin
    res_o.event_res     = ev;
    res_o.frame_ready   = show;
    res_o.payload_byte1 = shown[0];
    res_o.payload_byte2 = shown[1];
    res_o.payload_byte3 = shown[2];
    res_o.payload_byte4 = shown[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      sum_matched_q <= 1'b0;
      frame_held_q  <= 1'b0;
      running_sum_q <= '0;
    end else if (accept_i) begin
      byte_count_q  <= byte_count_d;
      sum_matched_q <= sum_matched_d;
      frame_held_q  <= frame_held_d;
      running_sum_q <= running_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && store_we) begin
      store_q[store_slot] <= item_i.rx_byte;
    end
  end

endmodule

`default_nettype wire

// File: hdl/serial_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none

// Deframer for a fixed serial frame: header, PAYLOAD_BYTES payload bytes, an 8-bit
// wrapping sum of header and payload, and a trailer. Each accepted item (one byte or
// one take command) yields exactly one result item; the frame state updates in the
// cycle the item is accepted and the result is registered. One item per cycle is
// sustained; a two-entry output stage (result register plus skid register) keeps
// input accepted while one result waits, and input stalls only when both hold.
// Header and trailer values are written on the configuration port, always ready.
module serial_frame_receiver import sfr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_item_t   in_item_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_item_t       out_item_o
);

  cfg_t      cfg_q;
  out_item_t res;
  out_item_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;
  logic      in_acc, out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i & ~skid_valid_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte  <= HeaderReset;
      cfg_q.trailer_byte <= TrailerReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegHeader:  cfg_q.header_byte  <= cfg_data_i;
        RegTrailer: cfg_q.trailer_byte <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  sfr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (in_acc),
    .item_i   (in_item_i),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Oldest result moves to the output first
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sfr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_checker import sfr_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  // Input stalls only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // Every accepted item leaves a result available next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted item produced no result");

  // No frame shown means all payload fields read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.frame_ready) |->
      (out_item_o.payload_byte1 == 8'h00 && out_item_o.payload_byte2 == 8'h00 &&
       out_item_o.payload_byte3 == 8'h00 && out_item_o.payload_byte4 == 8'h00))
    else $error("payload shown without a held frame");

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
